[src/hsl_pkg.sv]
// package for the hsl to rgb converter: word types, fixed-point constants, sextant codes
`default_nettype none
package hsl_pkg;

    // fixed-point format of hue, saturation and lightness
    localparam int FRAC_BITS = 15;
    localparam int IN_W      = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int BYTE_W    = 8;

    localparam logic [FX_W-1:0] FX_ONE  = FX_W'(1) << FRAC_BITS;
    localparam logic [FX_W-1:0] FX_HALF = FX_W'(1) << (FRAC_BITS - 1);

    // color sextants of the hue circle
    typedef enum logic [2:0] {
        SX_RED_YEL = 3'd0,
        SX_YEL_GRN = 3'd1,
        SX_GRN_CYN = 3'd2,
        SX_CYN_BLU = 3'd3,
        SX_BLU_MAG = 3'd4,
        SX_MAG_RED = 3'd5
    } t_sextant;

    // full hue lands one past the last sextant
    localparam logic [2:0] SX_WRAP = 3'd6;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] lightness;
    } t_hsl_word;

    typedef struct packed {
        logic [BYTE_W-1:0]   red;
        logic [BYTE_W-1:0]   green;
        logic [BYTE_W-1:0]   blue;
        logic [3*BYTE_W-1:0] packed_rgb;
    } t_rgb_word;

endpackage
`default_nettype wire

[src/hsl_to_rgb_converter.sv]
// hsl to rgb converter: six-stage pipeline from one hsl word to one rgb word
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | into      | i_in_valid / o_in_stall | i_in_word  (t_hsl_word)
//  out     | out of    | o_out_valid / i_out_stall | o_out_word (t_rgb_word)
//
// - six register stages; a taken word leaves from the stage 6 register
// - one word per cycle when the output side does not stall
// - the slowest stages each hold one product (16x16 l*s, then 16x15 (v-m)*fract)
// - synchronous active-low reset clears only the stage valid bits
// - a stall on the output, while the last stage holds a word, holds the whole
//   pipeline in place; the input stall rises only while that word is not taken
`default_nettype none
module hsl_to_rgb_converter
    import hsl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_hsl_word i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_rgb_word      o_out_word
);

    localparam int HS_W   = FX_W + 3;          // hue times six
    localparam int PROD_W = 2 * FX_W;          // l*s
    localparam int RAMP_W = FX_W + FRAC_BITS;  // (v-m)*fract
    localparam int SCL_W  = FX_W + BYTE_W;     // channel times 255

    // pipeline advance: everything moves unless the last word is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    logic [5:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------
    // stage 1: clamp inputs to one
    logic [FX_W-1:0] n1_h, n1_s, n1_l;
    logic [FX_W-1:0] r1_h, r1_s, r1_l;

    always_comb begin
        n1_h = (i_in_word.hue        > IN_W'(FX_ONE)) ? FX_ONE : FX_W'(i_in_word.hue);
        n1_s = (i_in_word.saturation > IN_W'(FX_ONE)) ? FX_ONE : FX_W'(i_in_word.saturation);
        n1_l = (i_in_word.lightness  > IN_W'(FX_ONE)) ? FX_ONE : FX_W'(i_in_word.lightness);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_h <= n1_h;
            r1_s <= n1_s;
            r1_l <= n1_l;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: l*s product, hue split into sextant and fraction
    logic [PROD_W-1:0]    n2_ls;
    logic [HS_W-1:0]      n2_h6;
    logic [2:0]           n2_sx_raw;
    t_sextant             n2_sx;
    logic [FRAC_BITS-1:0] n2_fract;

    logic [PROD_W-1:0]    r2_ls;
    t_sextant             r2_sx;
    logic [FRAC_BITS-1:0] r2_fract;
    logic [FX_W-1:0]      r2_s, r2_l;

    always_comb begin
        n2_ls     = PROD_W'(r1_l) * PROD_W'(r1_s);
        n2_h6     = (HS_W'(r1_h) << 2) + (HS_W'(r1_h) << 1);
        n2_sx_raw = n2_h6[FRAC_BITS+2:FRAC_BITS];
        n2_fract  = n2_h6[FRAC_BITS-1:0];
        n2_sx     = t_sextant'(n2_sx_raw);
        // full hue wraps to the red-yellow sextant at its start
        if (n2_sx_raw == SX_WRAP) begin
            n2_sx    = SX_RED_YEL;
            n2_fract = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ls    <= n2_ls;
            r2_sx    <= n2_sx;
            r2_fract <= n2_fract;
            r2_s     <= r1_s;
            r2_l     <= r1_l;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: v (largest channel) and m (smallest channel)
    logic [FX_W-1:0] n3_lsq;
    logic [FX_W:0]   n3_vpre;
    logic [FX_W-1:0] n3_v;
    logic [FX_W:0]   n3_l2;
    logic [FX_W-1:0] n3_m;

    t_sextant             r3_sx;
    logic [FRAC_BITS-1:0] r3_fract;
    logic [FX_W-1:0]      r3_v, r3_m, r3_l;
    logic                 r3_gray;

    always_comb begin
        n3_lsq = r2_ls[FRAC_BITS +: FX_W];
        // l*(1+s) equals l + l*s since l*one truncates exactly
        if (r2_l <= FX_HALF) begin
            n3_vpre = (FX_W+1)'(r2_l) + (FX_W+1)'(n3_lsq);
        end else begin
            n3_vpre = (FX_W+1)'(r2_l) + (FX_W+1)'(r2_s) - (FX_W+1)'(n3_lsq);
        end
        n3_v  = (n3_vpre > (FX_W+1)'(FX_ONE)) ? FX_ONE : n3_vpre[FX_W-1:0];
        n3_l2 = {r2_l, 1'b0};
        if (n3_l2 > (FX_W+1)'(n3_v)) begin
            n3_m = FX_W'(n3_l2 - (FX_W+1)'(n3_v));
        end else begin
            n3_m = '0;
        end
        if (n3_m > n3_v) begin
            n3_m = n3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_sx    <= r2_sx;
            r3_fract <= r2_fract;
            r3_v     <= n3_v;
            r3_m     <= n3_m;
            r3_l     <= r2_l;
            r3_gray  <= (n3_v == '0);
        end
    end

    // ---------------------------------------------------------------
    // stage 4: ramp product (v-m)*fract
    logic [RAMP_W-1:0] n4_prod;

    t_sextant          r4_sx;
    logic [RAMP_W-1:0] r4_prod;
    logic [FX_W-1:0]   r4_v, r4_m, r4_l;
    logic              r4_gray;

    assign n4_prod = RAMP_W'(r3_v - r3_m) * RAMP_W'(r3_fract);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sx   <= r3_sx;
            r4_prod <= n4_prod;
            r4_v    <= r3_v;
            r4_m    <= r3_m;
            r4_l    <= r3_l;
            r4_gray <= r3_gray;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: rising and falling ramps, channel pick by sextant
    logic [FX_W-1:0] n5_ramp, n5_mid1, n5_mid2;
    logic [FX_W-1:0] n5_r, n5_g, n5_b;
    logic [FX_W-1:0] r5_r, r5_g, r5_b;

    always_comb begin
        n5_ramp = r4_prod[FRAC_BITS +: FX_W];
        n5_mid1 = r4_m + n5_ramp;
        n5_mid2 = r4_v - n5_ramp;
        case (r4_sx)
            SX_RED_YEL: begin
                n5_r = r4_v;    n5_g = n5_mid1; n5_b = r4_m;
            end
            SX_YEL_GRN: begin
                n5_r = n5_mid2; n5_g = r4_v;    n5_b = r4_m;
            end
            SX_GRN_CYN: begin
                n5_r = r4_m;    n5_g = r4_v;    n5_b = n5_mid1;
            end
            SX_CYN_BLU: begin
                n5_r = r4_m;    n5_g = n5_mid2; n5_b = r4_v;
            end
            SX_BLU_MAG: begin
                n5_r = n5_mid1; n5_g = r4_m;    n5_b = r4_v;
            end
            default: begin
                n5_r = r4_v;    n5_g = r4_m;    n5_b = n5_mid2;
            end
        endcase
        // zero v gives gray at the lightness level
        if (r4_gray) begin
            n5_r = r4_l;
            n5_g = r4_l;
            n5_b = r4_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_r <= n5_r;
            r5_g <= n5_g;
            r5_b <= n5_b;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: scale by 255, truncate, pack; this is the output register
    function automatic logic [BYTE_W-1:0] to_byte(input logic [FX_W-1:0] c);
        logic [SCL_W-1:0] sc;
        logic [SCL_W-1:0] q;
        sc = (SCL_W'(c) << BYTE_W) - SCL_W'(c);
        q  = sc >> FRAC_BITS;
        return (q > SCL_W'(8'hFF)) ? 8'hFF : q[BYTE_W-1:0];
    endfunction

    logic [BYTE_W-1:0] n6_r, n6_g, n6_b;
    t_rgb_word         r6_word;

    always_comb begin
        n6_r = to_byte(r5_r);
        n6_g = to_byte(r5_g);
        n6_b = to_byte(r5_b);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_word.red        <= n6_r;
            r6_word.green      <= n6_g;
            r6_word.blue       <= n6_b;
            r6_word.packed_rgb <= {n6_r, n6_g, n6_b};
        end
    end

    assign o_out_valid = r_vld[5];
    assign o_out_word  = r6_word;

endmodule
`default_nettype wire

[src/hsl_checker.sv]
// port checker for the hsl to rgb converter, bound to the top level
`default_nettype none
module hsl_checker
    import hsl_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_hsl_word i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_rgb_word o_out_word
);

    // a held output word stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("held output word changed");

    // a stalled input word stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_word)))
        else $error("stalled input word changed");

    // packed word matches the three channel bytes
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.packed_rgb ==
            {o_out_word.red, o_out_word.green, o_out_word.blue}))
        else $error("packed word differs from channels");

    // input stall only comes from a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // a reset leaves no valid output word
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
